FILE: rtl/core/pkct_pkg.sv
// Package with the word, table entry and match types of the per-key counter delta tracker.
package pkct_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_W  = 2 * WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [KEY_W-1:0]  key_t;

    // One sample of a task's cumulative counters.
    typedef struct packed {
        word_t sample_time;
        word_t process_id;
        word_t thread_id;
        word_t voluntary_total;
        word_t involuntary_total;
        word_t migration_total;
    } in_word_t;

    // One result word.
    typedef struct packed {
        word_t record_index;
        word_t out_time;
        word_t out_process;
        word_t out_thread;
        word_t voluntary_delta;
        word_t involuntary_delta;
        word_t migration_delta;
        logic  first_seen;
        logic  table_full;
    } out_word_t;

    // One table slot as held in the memory.
    typedef struct packed {
        key_t  key;
        word_t voluntary;
        word_t involuntary;
        word_t migration;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Outcome of comparing one slot against the current sample.
    typedef struct packed {
        logic  hit;
        word_t voluntary_delta;
        word_t involuntary_delta;
        word_t migration_delta;
    } match_t;

endpackage

FILE: rtl/core/pkct_if.sv
// Valid/ready channel interfaces for the sample and result words.
interface pkct_in_if;
    logic              valid;
    logic              ready;
    pkct_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pkct_out_if;
    logic               valid;
    logic               ready;
    pkct_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/per_key_counter_delta_tracker_core.sv
// Top level of the per-key counter delta tracker: scan sequencer, table memory and result register.
//
//  Channel   Dir  Handshake        Word
//  samples   in   valid / ready    pkct_pkg::in_word_t  (time, key, three totals)
//  results   out  valid / ready    pkct_pkg::out_word_t (index, echo, deltas, flags)
//
// An accepted sample is scanned against the filled slots one slot per clock,
// a pace set by the single read port of the table memory. A hit ends the
// scan at the matching slot; a miss ends it after the last filled slot (an
// empty table still takes one scan step). The result then goes to the output
// register, and the next sample is taken once it has been loaded there.
// Reset clears the sequencer state, scan index, output valid flag, fill count
// and record counter; the slot
// contents need no clearing because slots fill in order and only the data of
// slots below the fill count is ever used. A stalled result holds in the output
// register, and a finished result waits in the sequencer until that register
// frees up; no new sample is taken meanwhile.
module per_key_counter_delta_tracker_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    pkct_in_if.sink           samples,
    pkct_out_if.source        results
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Sequencer state and control.
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    pkct_pkg::word_t        count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload holding registers.
    pkct_pkg::in_word_t     req_reg, req_next;
    pkct_pkg::word_t        index_reg, index_next;
    pkct_pkg::out_word_t    res_reg, res_next;
    pkct_pkg::out_word_t    out_data_reg, out_data_next;

    // Table memory ports.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    pkct_pkg::entry_t       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    pkct_pkg::entry_t       ram_rdata;

    pkct_pkg::match_t       match;
    logic                   accept;
    logic                   table_empty;
    logic                   last_slot;
    logic                   slot_hit;
    logic                   out_load;

    pkct_ram #(
        .WIDTH (pkct_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pkct_match u_match (
        .key               ({req_reg.process_id, req_reg.thread_id}),
        .voluntary_total   (req_reg.voluntary_total),
        .involuntary_total (req_reg.involuntary_total),
        .migration_total   (req_reg.migration_total),
        .entry             (ram_rdata),
        .result            (match)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // The memory read data always belongs to idx_reg while scanning; the next
    // slot is requested while the current one is compared, so the scan runs one slot per clock.
    assign table_empty = (fill_reg == '0);
    assign last_slot   = table_empty || ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign slot_hit    = !table_empty && match.hit;
    assign ram_raddr   = (state_reg == S_IDLE) ? '0 : IDX_W'(idx_reg + IDX_W'(1));

    // New slot contents are the same for a hit and a stored miss.
    assign ram_wdata = '{
        key:         {req_reg.process_id, req_reg.thread_id},
        voluntary:   req_reg.voluntary_total,
        involuntary: req_reg.involuntary_total,
        migration:   req_reg.migration_total
    };

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        index_next     = index_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !results.ready;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = samples.data;
                    index_next = count_reg;
                    count_next = count_reg + pkct_pkg::word_t'(1);
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                res_next.record_index = index_reg;
                res_next.out_time     = req_reg.sample_time;
                res_next.out_process  = req_reg.process_id;
                res_next.out_thread   = req_reg.thread_id;
                if (slot_hit)
                begin
                    // Known task: report deltas and refresh the stored totals.
                    res_next.voluntary_delta   = match.voluntary_delta;
                    res_next.involuntary_delta = match.involuntary_delta;
                    res_next.migration_delta   = match.migration_delta;
                    res_next.first_seen        = 1'b0;
                    res_next.table_full        = 1'b0;
                    ram_we                     = 1'b1;
                    ram_waddr                  = idx_reg;
                    state_next                 = S_DONE;
                end
                else if (last_slot)
                begin
                    // New task: zero deltas, store it in the next free slot if any.
                    res_next.voluntary_delta   = '0;
                    res_next.involuntary_delta = '0;
                    res_next.migration_delta   = '0;
                    res_next.first_seen        = 1'b1;
                    res_next.table_full        = (fill_reg == FULL_COUNT);
                    if (fill_reg != FULL_COUNT)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + IDX_W'(1));
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        index_reg    <= index_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // The fill count never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond table size");

    // The fill count never shrinks outside reset.
    a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_reg >= $past(fill_reg))
        else $error("fill count decreased");

    // A full flag is only reported when every slot was taken.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_reg.table_full) |-> (fill_reg == FULL_COUNT))
        else $error("table_full reported with free slots");

    // A new task always carries zero deltas, and a full table implies a new task.
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ((!res_reg.first_seen || (res_reg.voluntary_delta == '0
            && res_reg.involuntary_delta == '0 && res_reg.migration_delta == '0))
            && (!res_reg.table_full || res_reg.first_seen)))
        else $error("inconsistent new-task result");

    // The scan index stays below the fill count while scanning a non-empty table.
    a_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !table_empty) |-> (CNT_W'(idx_reg) < fill_reg))
        else $error("scan index past filled slots");

endmodule

FILE: rtl/core/pkct_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pkct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/pkct_match.sv
// Key compare and counter delta unit shared by every step of the table scan.
module pkct_match (
    input  pkct_pkg::key_t   key,
    input  pkct_pkg::word_t  voluntary_total,
    input  pkct_pkg::word_t  involuntary_total,
    input  pkct_pkg::word_t  migration_total,
    input  pkct_pkg::entry_t entry,
    output pkct_pkg::match_t result
);

    // Deltas wrap modulo 2^32, so a plain subtraction is exact.
    always_comb
    begin
        result.hit               = (entry.key == key);
        result.voluntary_delta   = voluntary_total - entry.voluntary;
        result.involuntary_delta = involuntary_total - entry.involuntary;
        result.migration_delta   = migration_total - entry.migration;
    end

endmodule
